// ----- rtl/dclc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dclc_pkg: shared types and constants of the two-channel lux calculator
// Payload structs, band codes, Q20 coefficients and the ratio^1.4 table.
// ----------------------------------------------------------------------------
package dclc_pkg;

   localparam int POWER_TABLE_DEPTH   = 64;
   localparam int RATIO_FRACTION_BITS = 16;
   localparam int COEF_FRAC           = 20;

   localparam int COUNT_W = 16;
   localparam int LUX_W   = 11;
   localparam int BAND_W  = 3;
   localparam int Q20_W   = 32;
   localparam int POW_W   = COEF_FRAC;

   localparam int TWO_D     = 2 * POWER_TABLE_DEPTH;
   localparam int TWO_D_W   = $clog2(TWO_D + 1);
   localparam int POS_W     = RATIO_FRACTION_BITS + TWO_D_W;
   localparam int TAB_IDX_W = $clog2(POWER_TABLE_DEPTH + 1);
   localparam int WIDE_W    = 5 * (COEF_FRAC + 1) + 2 * TWO_D_W + 2 * TAB_IDX_W + 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // coefficients in Q20
   localparam logic [15:0] K_B1_BB = 16'd31877;
   localparam logic [15:0] K_B1_PW = 16'd65012;
   localparam logic [15:0] K_B2_BB = 16'd23488;
   localparam logic [15:0] K_B2_IR = 16'd32506;
   localparam logic [15:0] K_B3_BB = 16'd13422;
   localparam logic [15:0] K_B3_IR = 16'd16043;
   localparam logic [15:0] K_B4_BB = 16'd1531;
   localparam logic [15:0] K_B4_IR = 16'd1174;

   localparam logic [LUX_W-1:0] LUX_MAX = '1;

   localparam logic [BAND_W-1:0] BAND_BB_ZERO = 3'd0;
   localparam logic [BAND_W-1:0] BAND_LOW     = 3'd1;
   localparam logic [BAND_W-1:0] BAND_MID     = 3'd2;
   localparam logic [BAND_W-1:0] BAND_HIGH    = 3'd3;
   localparam logic [BAND_W-1:0] BAND_TOP     = 3'd4;
   localparam logic [BAND_W-1:0] BAND_OVER    = 3'd5;

   typedef struct packed {
      logic [COUNT_W-1:0] broadband_count;
      logic [COUNT_W-1:0] infrared_count;
   } req_payload_type;

   typedef struct packed {
      logic [LUX_W-1:0]  lux_value;
      logic [BAND_W-1:0] ratio_band;
   } rsp_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] broadband_count;
      logic [COUNT_W-1:0] infrared_count;
      logic [BAND_W-1:0]  band;
   } queue_item_type;

   typedef logic [POWER_TABLE_DEPTH:0][POW_W-1:0] pow_tab_type;

   localparam logic [COEF_FRAC:0] ONE_Q20 = (COEF_FRAC + 1)'(1) << COEF_FRAC;

   // entry i holds (i/2D) * (i/2D)^0.4, the root found by bitwise search on z^5 <= x^2
   function automatic pow_tab_type build_pow_tab();
      pow_tab_type        tab;
      logic [WIDE_W-1:0]  lhs;
      logic [WIDE_W-1:0]  rhs;
      logic [COEF_FRAC:0] z;
      logic [COEF_FRAC:0] cand;
      logic [63:0]        scaled;
      tab = '0;
      for (int i = 0; i <= POWER_TABLE_DEPTH; i++) begin
         z   = '0;
         rhs = WIDE_W'(i * i) << (5 * COEF_FRAC);
         for (int b = COEF_FRAC; b >= 0; b--) begin
            cand = z | ((COEF_FRAC + 1)'(1) << b);
            lhs  = WIDE_W'(cand);
            for (int n = 1; n < 5; n++) begin
               lhs = lhs * WIDE_W'(cand);
            end
            lhs = lhs * WIDE_W'(TWO_D) * WIDE_W'(TWO_D);
            if (cand <= ONE_Q20 && lhs <= rhs) begin
               z = cand;
            end
         end
         scaled = 64'(i) * 64'(z);
         tab[i] = POW_W'(scaled / 64'(TWO_D));
      end
      return tab;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

endpackage
`default_nettype wire

// ----- rtl/dclc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dclc_front: input stage
// Takes a beat, sorts the ratio into its band by cross-products, holds it
// until the queue takes it.
// ----------------------------------------------------------------------------
module dclc_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire dclc_pkg::req_payload_type req_payload,
   output logic                      item_valid,
   input  wire                       item_ready,
   output dclc_pkg::queue_item_type  item
);
   import dclc_pkg::*;

   logic           valid_ff;
   queue_item_type item_ff;
   queue_item_type item_in;

   logic [COUNT_W-1:0] bb;
   logic [COUNT_W-1:0] ir;
   logic [16:0]        ir_x2;
   logic [22:0]        ir_x100;
   logic [22:0]        bb_x61;
   logic [18:0]        ir_x5;
   logic [18:0]        bb_x4;
   logic [19:0]        ir_x10;
   logic [19:0]        bb_x13;

   assign bb = req_payload.broadband_count;
   assign ir = req_payload.infrared_count;

   always_comb begin
      ir_x2   = {ir, 1'b0};
      ir_x100 = 23'(ir) * 23'd100;
      bb_x61  = 23'(bb) * 23'd61;
      ir_x5   = 19'(ir) * 19'd5;
      bb_x4   = {1'b0, bb, 2'b00};
      ir_x10  = 20'(ir) * 20'd10;
      bb_x13  = 20'(bb) * 20'd13;

      item_in.broadband_count = bb;
      item_in.infrared_count  = ir;
      if (bb == '0) begin
         item_in.band = BAND_BB_ZERO;
      end else if (ir_x2 <= 17'(bb)) begin
         item_in.band = BAND_LOW;
      end else if (ir_x100 <= bb_x61) begin
         item_in.band = BAND_MID;
      end else if (ir_x5 <= bb_x4) begin
         item_in.band = BAND_HIGH;
      end else if (ir_x10 <= bb_x13) begin
         item_in.band = BAND_TOP;
      end else begin
         item_in.band = BAND_OVER;
      end
   end

   assign req_ready  = !valid_ff || item_ready;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/dclc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dclc_fifo: short queue between front and back
// Registered entries, no pass-through, so both sides stall on their own.
// ----------------------------------------------------------------------------
module dclc_fifo (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire dclc_pkg::queue_item_type in_item,
   output logic                     out_valid,
   input  wire                      out_ready,
   output dclc_pkg::queue_item_type out_item
);
   import dclc_pkg::*;

   queue_item_type         entries_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/dclc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dclc_back: lux datapath pipeline
// One ratio bit per divider stage, table lookup and interpolation, the
// band formula, then clamp and truncate into the output register.
// ----------------------------------------------------------------------------
module dclc_back (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire dclc_pkg::queue_item_type in_item,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output dclc_pkg::rsp_payload_type rsp_payload
);
   import dclc_pkg::*;

   localparam int DIV_N   = RATIO_FRACTION_BITS;
   localparam int ST_IDX  = DIV_N + 1;
   localparam int ST_LKP  = DIV_N + 2;
   localparam int ST_INT  = DIV_N + 3;
   localparam int ST_TERM = DIV_N + 4;
   localparam int TERM_W  = Q20_W + POW_W;
   localparam int INTP_W  = POW_W + DIV_N;

   typedef struct packed {
      logic [COUNT_W-1:0] bb;
      logic [BAND_W-1:0]  band;
      logic [Q20_W-1:0]   pos;
      logic [Q20_W-1:0]   neg;
   } carry_type;

   logic adv;

   logic [ST_TERM:0] vld_ff;
   carry_type        car_ff [0:ST_TERM];
   carry_type        car_in;

   logic [COUNT_W:0] rem_ff [0:DIV_N];
   logic [DIV_N-1:0] quo_ff [0:DIV_N];
   logic [COUNT_W:0] rem_in [1:DIV_N];
   logic [DIV_N-1:0] quo_in [1:DIV_N];
   logic [COUNT_W:0] dbl    [1:DIV_N];
   logic             ge     [1:DIV_N];

   logic [POS_W-1:0]     pos_idx_ff;
   logic [TWO_D_W-1:0]   k_raw;
   logic [TAB_IDX_W-1:0] k_sel;
   logic [TAB_IDX_W-1:0] k_nxt;
   logic [POW_W-1:0]     lo;
   logic [POW_W-1:0]     hi;
   logic [POW_W-1:0]     lo_ff;
   logic [POW_W-1:0]     step_ff;
   logic [DIV_N-1:0]     frac_ff;
   logic [INTP_W-1:0]    intp;
   logic [POW_W-1:0]     pw_ff;
   logic [Q20_W-1:0]     kbb_ff;
   logic [TERM_W-1:0]    term_full;
   logic [Q20_W-1:0]     term_ff;

   logic [Q20_W-1:0]             neg_sel;
   logic [Q20_W-1:0]             diff;
   logic [Q20_W-COEF_FRAC-1:0]   whole;
   logic                         rsp_valid_ff;
   rsp_payload_type              rsp_ff;
   rsp_payload_type              rsp_in;

   // whole pipeline moves together; only the output register can hold it
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign in_ready = adv;

   always_comb begin
      car_in.bb   = in_item.broadband_count;
      car_in.band = in_item.band;
      case (in_item.band)
         BAND_LOW: begin
            car_in.pos = Q20_W'(in_item.broadband_count) * Q20_W'(K_B1_BB);
            car_in.neg = '0;
         end
         BAND_MID: begin
            car_in.pos = Q20_W'(in_item.broadband_count) * Q20_W'(K_B2_BB);
            car_in.neg = Q20_W'(in_item.infrared_count) * Q20_W'(K_B2_IR);
         end
         BAND_HIGH: begin
            car_in.pos = Q20_W'(in_item.broadband_count) * Q20_W'(K_B3_BB);
            car_in.neg = Q20_W'(in_item.infrared_count) * Q20_W'(K_B3_IR);
         end
         BAND_TOP: begin
            car_in.pos = Q20_W'(in_item.broadband_count) * Q20_W'(K_B4_BB);
            car_in.neg = Q20_W'(in_item.infrared_count) * Q20_W'(K_B4_IR);
         end
         default: begin
            car_in.pos = '0;
            car_in.neg = '0;
         end
      endcase
   end

   // restoring divide, one quotient bit per stage; ir < bb holds in the low band
   always_comb begin
      for (int d = 1; d <= DIV_N; d++) begin
         dbl[d]    = {rem_ff[d-1][COUNT_W-1:0], 1'b0};
         ge[d]     = dbl[d] >= {1'b0, car_ff[d-1].bb};
         rem_in[d] = ge[d] ? dbl[d] - {1'b0, car_ff[d-1].bb} : dbl[d];
         quo_in[d] = quo_ff[d-1];
         quo_in[d][DIV_N-d] = ge[d];
      end
   end

   // table position, clamped to the last entry
   always_comb begin
      k_raw = pos_idx_ff[POS_W-1:DIV_N];
      if (k_raw > TWO_D_W'(POWER_TABLE_DEPTH)) begin
         k_sel = TAB_IDX_W'(POWER_TABLE_DEPTH);
      end else begin
         k_sel = k_raw[TAB_IDX_W-1:0];
      end
      k_nxt = (k_sel == TAB_IDX_W'(POWER_TABLE_DEPTH)) ? k_sel : k_sel + 1'b1;
      lo    = POW_TAB[k_sel];
      hi    = POW_TAB[k_nxt];
      if (hi < lo) begin
         hi = lo;
      end
   end

   assign intp      = INTP_W'(step_ff) * INTP_W'(frac_ff);
   assign term_full = TERM_W'(kbb_ff) * TERM_W'(pw_ff);

   always_comb begin
      neg_sel = (car_ff[ST_TERM].band == BAND_LOW) ? term_ff : car_ff[ST_TERM].neg;
      diff    = car_ff[ST_TERM].pos - neg_sel;
      whole   = diff[Q20_W-1:COEF_FRAC];
      rsp_in.ratio_band = car_ff[ST_TERM].band;
      if (neg_sel >= car_ff[ST_TERM].pos) begin
         rsp_in.lux_value = '0;
      end else if (whole > (Q20_W - COEF_FRAC)'(LUX_MAX)) begin
         rsp_in.lux_value = LUX_MAX;
      end else begin
         rsp_in.lux_value = whole[LUX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[ST_TERM-1:0], in_valid};
         rsp_valid_ff <= vld_ff[ST_TERM];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[0] <= car_in;
         rem_ff[0] <= (COUNT_W + 1)'(in_item.infrared_count);
         quo_ff[0] <= '0;
         for (int s = 1; s <= ST_TERM; s++) begin
            car_ff[s] <= car_ff[s-1];
         end
         for (int d = 1; d <= DIV_N; d++) begin
            rem_ff[d] <= rem_in[d];
            quo_ff[d] <= quo_in[d];
         end
         pos_idx_ff <= POS_W'(quo_ff[DIV_N]) * POS_W'(TWO_D);
         lo_ff      <= lo;
         step_ff    <= hi - lo;
         frac_ff    <= pos_idx_ff[DIV_N-1:0];
         pw_ff      <= lo_ff + POW_W'(intp >> DIV_N);
         kbb_ff     <= Q20_W'(car_ff[ST_LKP].bb) * Q20_W'(K_B1_PW);
         term_ff    <= Q20_W'(term_full >> COEF_FRAC);
         rsp_ff     <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/dual_channel_lux_calculator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_lux_calculator: two-channel light sensor lux calculator
// Broadband and infrared counts in, truncated lux and ratio band out.
// ----------------------------------------------------------------------------
// throughput: one beat per cycle while results are taken;
// the ratio divider is a pipeline of one bit per stage
// a held result stalls the whole back pipeline; input and queue take 3 more beats
// reset clears all valid state; no result is shown until a beat has passed through
// ----------------------------------------------------------------------------
module dual_channel_lux_calculator (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire dclc_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output dclc_pkg::rsp_payload_type rsp_payload
);
   import dclc_pkg::*;

   logic           front_valid;
   logic           front_ready;
   queue_item_type front_item;
   logic           queue_valid;
   logic           queue_ready;
   queue_item_type queue_item;

   dclc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .item_valid  (front_valid),
      .item_ready  (front_ready),
      .item        (front_item)
   );

   dclc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   dclc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_ready    (queue_ready),
      .in_item     (queue_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- rtl/dclc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dclc_checker: port-level checks of the lux calculator
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module dclc_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire dclc_pkg::rsp_payload_type rsp_payload
);
   import dclc_pkg::*;

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_band_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.ratio_band <= BAND_OVER)
      else $error("ratio band out of range");

   // zero broadband and out-of-range ratio give no light
   a_zero_lux: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.ratio_band == BAND_BB_ZERO ||
                    rsp_payload.ratio_band == BAND_OVER)
      |-> rsp_payload.lux_value == '0)
      else $error("nonzero lux outside the formula bands");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind dual_channel_lux_calculator dclc_checker u_dclc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
`default_nettype wire

// ----- tb/sv/tb_dual_channel_lux_calculator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_channel_lux_calculator: self-checking bench of the lux calculator
// Drives count pairs with random gaps, predicts lux and band per beat in an
// integer model of its own and checks every result beat in order. One long
// receiver hold-off fills the pipeline so that the input side stalls.
// ----------------------------------------------------------------------------
module tb_dual_channel_lux_calculator;
   import dclc_pkg::*;

   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          RANDOM_PAIRS = 650;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          LUT_SPAN     = 2 * POWER_TABLE_DEPTH;

   // illuminance coefficients in q20
   localparam longint unsigned C_LOW_BB  = 31877;
   localparam longint unsigned C_LOW_POW = 65012;
   localparam longint unsigned C_MID_BB  = 23488;
   localparam longint unsigned C_MID_IR  = 32506;
   localparam longint unsigned C_HIGH_BB = 13422;
   localparam longint unsigned C_HIGH_IR = 16043;
   localparam longint unsigned C_TOP_BB  = 1531;
   localparam longint unsigned C_TOP_IR  = 1174;
   localparam longint unsigned LUX_CEIL  = 2047;

   typedef struct {
      rsp_payload_type result;
      req_payload_type source;
   } lux_expectation_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   req_payload_type     count_pairs[$];
   lux_expectation_type pending_lux[$];
   lux_expectation_type want;
   logic [31:0]         power_lut [0:POWER_TABLE_DEPTH];

   logic        out_of_reset = 1'b0;
   logic        req_taken = 1'b0;
   logic        rsp_taken = 1'b0;
   logic        rx_stall = 1'b0;
   int unsigned tx_gap = 0;
   int unsigned tx_burst = 0;
   int unsigned rx_wait = 0;
   int unsigned rx_burst = 0;
   int unsigned wait_now;
   int unsigned cycle_count = 0;
   int unsigned rsp_count = 0;
   int unsigned error_count = 0;

   dual_channel_lux_calculator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // entry i is (i/2D)^1.4 in q20, the 0.4 root found bit by bit on z^5 <= x^2
   task automatic build_power_lut();
      logic [127:0]         lhs;
      logic [127:0]         rhs;
      logic [COEF_FRAC:0]   z;
      logic [COEF_FRAC:0]   cand;
      longint unsigned      scaled;
      for (int i = 0; i <= POWER_TABLE_DEPTH; i++) begin
         z   = '0;
         rhs = 128'(i * i) << (5 * COEF_FRAC);
         for (int b = COEF_FRAC; b >= 0; b--) begin
            cand = z | ((COEF_FRAC + 1)'(1) << b);
            lhs  = 128'(cand) * cand * cand * cand * cand * LUT_SPAN * LUT_SPAN;
            if (cand <= ((COEF_FRAC + 1)'(1) << COEF_FRAC) && lhs <= rhs) begin
               z = cand;
            end
         end
         scaled       = longint'(i) * longint'(z);
         power_lut[i] = 32'(scaled / LUT_SPAN);
      end
   endtask

   function automatic lux_expectation_type predict_lux(input req_payload_type beat);
      longint unsigned  bb;
      longint unsigned  ir;
      longint unsigned  ratio_q;
      longint unsigned  pos;
      longint unsigned  k;
      longint unsigned  f;
      longint unsigned  lo;
      longint unsigned  hi;
      longint unsigned  pw;
      longint unsigned  plus;
      longint unsigned  minus;
      longint unsigned  lux;
      logic [BAND_W-1:0] band;
      lux_expectation_type e;
      bb    = beat.broadband_count;
      ir    = beat.infrared_count;
      plus  = 0;
      minus = 0;
      if (bb == 0) begin
         band = BAND_BB_ZERO;
      end else if (2 * ir <= bb) begin
         band    = BAND_LOW;
         ratio_q = (ir << RATIO_FRACTION_BITS) / bb;
         pos     = ratio_q * LUT_SPAN;
         k       = pos >> RATIO_FRACTION_BITS;
         f       = pos & ((64'd1 << RATIO_FRACTION_BITS) - 1);
         if (k > POWER_TABLE_DEPTH) begin
            k = POWER_TABLE_DEPTH;
         end
         lo = power_lut[k];
         hi = (k < POWER_TABLE_DEPTH) ? power_lut[k + 1] : lo;
         if (hi < lo) begin
            hi = lo;
         end
         pw    = lo + (((hi - lo) * f) >> RATIO_FRACTION_BITS);
         plus  = C_LOW_BB * bb;
         minus = (C_LOW_POW * bb * pw) >> COEF_FRAC;
      end else if (100 * ir <= 61 * bb) begin
         band  = BAND_MID;
         plus  = C_MID_BB * bb;
         minus = C_MID_IR * ir;
      end else if (5 * ir <= 4 * bb) begin
         band  = BAND_HIGH;
         plus  = C_HIGH_BB * bb;
         minus = C_HIGH_IR * ir;
      end else if (10 * ir <= 13 * bb) begin
         band  = BAND_TOP;
         plus  = C_TOP_BB * bb;
         minus = C_TOP_IR * ir;
      end else begin
         band = BAND_OVER;
      end
      // negative or zero formula result clamps to zero
      if (minus >= plus) begin
         lux = 0;
      end else begin
         lux = (plus - minus) >> COEF_FRAC;
         if (lux > LUX_CEIL) begin
            lux = LUX_CEIL;
         end
      end
      e.result.lux_value  = LUX_W'(lux);
      e.result.ratio_band = band;
      e.source            = beat;
      return e;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic push_pair(input int bb, input int ir);
      req_payload_type beat;
      beat.broadband_count = COUNT_W'(bb);
      beat.infrared_count  = COUNT_W'(ir);
      count_pairs.push_back(beat);
   endtask

   // sender: one beat offered at a time, held until taken, random gap after it
   always @(negedge clock) begin
      if (out_of_reset) begin
         if (req_valid && !req_taken) begin
            // beat still waiting for ready
         end else if (tx_gap > 0) begin
            req_valid <= 1'b0;
            tx_gap    <= tx_gap - 1;
         end else if (count_pairs.size() > 0) begin
            req_valid   <= 1'b1;
            req_payload <= count_pairs.pop_front();
            if (tx_burst > 0) begin
               tx_burst <= tx_burst - 1;
               tx_gap   <= 0;
            end else if ($urandom_range(0, 23) == 0) begin
               tx_burst <= $urandom_range(8, 40);
               tx_gap   <= 0;
            end else begin
               tx_gap <= $urandom_range(0, 11);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: fresh wait drawn after every taken result beat
   always @(negedge clock) begin
      if (out_of_reset) begin
         wait_now = rx_wait;
         if (rsp_taken) begin
            if (rx_burst > 0) begin
               rx_burst <= rx_burst - 1;
               wait_now = 0;
            end else if ($urandom_range(0, 23) == 0) begin
               rx_burst <= $urandom_range(8, 40);
               wait_now = 0;
            end else begin
               wait_now = $urandom_range(0, 11);
            end
         end else if (wait_now > 0) begin
            wait_now = wait_now - 1;
         end
         rx_wait   <= wait_now;
         rsp_ready <= (wait_now == 0) && !rx_stall;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      cycle_count  <= cycle_count + 1;
      out_of_reset <= !reset;
      req_taken    <= !reset && req_valid && req_ready;
      rsp_taken    <= !reset && rsp_valid && rsp_ready;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_lux.push_back(predict_lux(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (pending_lux.size() == 0) begin
               report_mismatch($sformatf("result beat lux %0d band %0d with none pending",
                                         rsp_payload.lux_value, rsp_payload.ratio_band));
            end else begin
               want = pending_lux.pop_front();
               if (rsp_payload.lux_value !== want.result.lux_value) begin
                  report_mismatch($sformatf("lux_value %0d, wanted %0d (bb %0d ir %0d)",
                                            rsp_payload.lux_value, want.result.lux_value,
                                            want.source.broadband_count,
                                            want.source.infrared_count));
               end
               if (rsp_payload.ratio_band !== want.result.ratio_band) begin
                  report_mismatch($sformatf("ratio_band %0d, wanted %0d (bb %0d ir %0d)",
                                            rsp_payload.ratio_band, want.result.ratio_band,
                                            want.source.broadband_count,
                                            want.source.infrared_count));
               end
            end
         end
      end
   end

   // long receiver hold-off so the pipeline backs up into the input
   initial begin
      while (rsp_count < 80) begin
         @(posedge clock);
      end
      rx_stall = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_stall = 1'b0;
   end

   initial begin
      int edge_num [4];
      int edge_den [4];
      int pick;
      int sel;
      int bb;
      int ir;
      edge_num = '{1, 61, 4, 13};
      edge_den = '{2, 100, 5, 10};
      build_power_lut();

      // corners, exact band edges and the zero-broadband and over-ratio cases
      push_pair(0, 0);
      push_pair(0, 65535);
      push_pair(65535, 0);
      push_pair(65535, 65535);
      push_pair(1, 0);
      push_pair(1, 1);
      push_pair(3, 1);
      push_pair(2, 1);
      push_pair(65534, 32767);
      push_pair(65535, 32767);
      push_pair(65535, 32768);
      push_pair(100, 61);
      push_pair(100, 62);
      push_pair(65535, 39976);
      push_pair(5, 4);
      push_pair(65535, 52428);
      push_pair(65535, 52429);
      push_pair(10, 13);
      push_pair(50000, 65000);
      push_pair(50000, 65001);
      push_pair(10, 14);
      push_pair(1, 65535);
      push_pair(43690, 21845);
      push_pair(21845, 43690);

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         pick = $urandom_range(0, 19);
         if ($urandom_range(0, 3) == 0) begin
            bb = $urandom_range(1, 255);
         end else begin
            bb = $urandom_range(1, 65535);
         end
         if (pick == 0) begin
            bb = 0;
            ir = $urandom_range(0, 65535);
         end else if (pick < 4) begin
            bb = $urandom_range(0, 65535);
            ir = $urandom_range(0, 65535);
         end else if (pick < 8) begin
            // right at a band edge, one count either side
            sel = $urandom_range(0, 3);
            ir  = (bb * edge_num[sel]) / edge_den[sel] + $urandom_range(0, 2) - 1;
         end else begin
            ir = (bb * $urandom_range(0, 1400)) / 1000;
         end
         if (ir < 0) begin
            ir = 0;
         end else if (ir > 65535) begin
            ir = 65535;
         end
         push_pair(bb, ir);
      end

      repeat (12) @(negedge clock);
      reset = 1'b0;

      while (count_pairs.size() != 0 || req_valid || pending_lux.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/dclc_pkg.sv
rtl/dclc_front.sv
rtl/dclc_fifo.sv
rtl/dclc_back.sv
rtl/dual_channel_lux_calculator.sv
rtl/dclc_checker.sv
tb/sv/tb_dual_channel_lux_calculator.sv
